FILE: sv/khr_pkg.sv
// Shared types and codes for the keyed handle registry.
package khr_pkg;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_ACQUIRE = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_PID  = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_LOCKED    = 3'd5
    } t_status;

    typedef struct packed {
        t_req        req_type;
        logic [31:0] process_id;
        logic [15:0] mosaic_index;
        logic [15:0] texture_number;
        logic [63:0] handle_in;
        logic [5:0]  slot_in;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [63:0] handle_out;
        logic [5:0]  slot_out;
        logic [6:0]  entry_count;
    } t_out_item;

    // One table slot as stored in memory; a zero key marks an empty slot.
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] handle;
        logic        locked;
    } t_entry;

    localparam int unsigned CFG_W = 7;
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd64;

endpackage

FILE: sv/khr_ram.sv
// Generic simple dual-port RAM with registered read.
module khr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/khr_ctrl.sv
// Request sequencer: clears the table, scans it, decides and writes back.
module khr_ctrl #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  khr_pkg::t_in_item          i_in_item,
    input  logic [$clog2(DEPTH+1)-1:0] i_lim,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output khr_pkg::t_out_item         o_res_item
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = $bits(khr_pkg::t_entry);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL,
        S_DONE
    } t_state;

    t_state          r_state;
    khr_pkg::t_req   r_req;
    logic [63:0]     r_key;
    logic [63:0]     r_handle_in;
    logic [5:0]      r_slot_in;
    logic [CW-1:0]   r_addr;
    logic            r_chk_vld;
    logic [AW-1:0]   r_chk_addr;
    logic            r_hit;
    logic [AW-1:0]   r_hit_slot;
    khr_pkg::t_entry r_hit_ent;
    logic            r_emp_vld;
    logic [AW-1:0]   r_emp_slot;
    logic            r_zero_pid;
    logic            r_rel_ok;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    logic            accept;
    logic            commit;
    logic            match;
    logic            empty;
    logic            scan_issue;
    logic            in_rel_ok;
    logic [63:0]     in_key;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    khr_pkg::t_entry ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    khr_pkg::t_entry ram_rdata;
    logic [EW-1:0]   ram_rdata_bits;

    logic            dec_we;
    logic [AW-1:0]   dec_waddr;
    khr_pkg::t_entry dec_wdata;
    khr_pkg::t_out_item res;

    khr_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    assign ram_rdata  = khr_pkg::t_entry'(ram_rdata_bits);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_key     = {i_in_item.process_id, i_in_item.mosaic_index,
                         i_in_item.texture_number};
    assign in_rel_ok  = (32'(i_in_item.slot_in) < DEPTH);

    assign match      = (r_state == S_SCAN) && r_chk_vld && (ram_rdata.key == r_key);
    assign empty      = (r_state == S_SCAN) && r_chk_vld && (ram_rdata.key == 64'd0);
    assign scan_issue = (r_state == S_SCAN) && !match && (r_addr < i_lim);

    assign o_res_valid = (r_state == S_DONE);
    assign commit      = o_res_valid && i_res_ready;
    assign o_res_item  = res;

    // Decide the answer from what the scan left behind.
    always_comb begin
        res             = '0;
        res.status      = khr_pkg::ST_OK;
        dec_we          = 1'b0;
        dec_waddr       = r_hit_slot;
        dec_wdata       = r_hit_ent;
        n_count         = r_count;
        if (r_req == khr_pkg::REQ_RELEASE) begin
            if (r_rel_ok) begin
                dec_we           = 1'b1;
                dec_waddr        = AW'(r_slot_in);
                dec_wdata.locked = 1'b0;
                res.slot_out     = r_slot_in;
            end else begin
                res.status = khr_pkg::ST_NOT_FOUND;
            end
        end else if (r_zero_pid) begin
            res.status = khr_pkg::ST_ZERO_PID;
        end else if (r_req == khr_pkg::REQ_ADD) begin
            if (r_hit) begin
                res.slot_out = 6'(r_hit_slot);
                if (r_hit_ent.handle != r_handle_in) begin
                    res.status = khr_pkg::ST_MISMATCH;
                end
            end else if (!r_emp_vld || (r_count >= i_lim)) begin
                res.status = khr_pkg::ST_FULL;
            end else begin
                dec_we           = 1'b1;
                dec_waddr        = r_emp_slot;
                dec_wdata.key    = r_key;
                dec_wdata.handle = r_handle_in;
                dec_wdata.locked = 1'b0;
                n_count          = r_count + CW'(1);
                res.slot_out     = 6'(r_emp_slot);
            end
        end else begin
            if (!r_hit) begin
                res.status = khr_pkg::ST_NOT_FOUND;
            end else if (r_hit_ent.locked) begin
                res.status   = khr_pkg::ST_LOCKED;
                res.slot_out = 6'(r_hit_slot);
            end else if (r_req == khr_pkg::REQ_REMOVE) begin
                dec_we       = 1'b1;
                dec_wdata    = '0;
                res.slot_out = 6'(r_hit_slot);
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
            end else begin
                dec_we           = 1'b1;
                dec_wdata.locked = 1'b1;
                res.handle_out   = r_hit_ent.handle;
                res.slot_out     = 6'(r_hit_slot);
            end
        end
        res.entry_count = 7'(n_count);
    end

    // Memory port selection: clearing sweep, scan reads, release read, write-back.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_addr[AW-1:0];
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (commit) begin
            ram_we    = dec_we;
            ram_waddr = dec_waddr;
            ram_wdata = dec_wdata;
        end
        if (accept && (i_in_item.req_type == khr_pkg::REQ_RELEASE) && in_rel_ok) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(i_in_item.slot_in);
        end else if (scan_issue) begin
            ram_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_chk_vld <= 1'b0;
            r_count   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + CW'(1);
                    if (r_addr == CW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_req       <= i_in_item.req_type;
                        r_key       <= in_key;
                        r_handle_in <= i_in_item.handle_in;
                        r_slot_in   <= i_in_item.slot_in;
                        r_zero_pid  <= (i_in_item.process_id == 32'd0);
                        r_rel_ok    <= in_rel_ok;
                        r_hit       <= 1'b0;
                        r_emp_vld   <= 1'b0;
                        r_chk_vld   <= 1'b0;
                        r_addr      <= (i_in_item.req_type == khr_pkg::REQ_ADD) ?
                                       CW'(1) : '0;
                        if (i_in_item.req_type == khr_pkg::REQ_RELEASE) begin
                            r_state <= in_rel_ok ? S_REL : S_DONE;
                        end else if (i_in_item.process_id == 32'd0) begin
                            r_state <= S_DONE;
                        end else if ((i_in_item.req_type != khr_pkg::REQ_ADD) &&
                                     (r_count == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_REL: begin
                    r_hit_ent <= ram_rdata;
                    r_state   <= S_DONE;
                end
                S_SCAN: begin
                    if (match) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_chk_addr;
                        r_hit_ent  <= ram_rdata;
                        r_chk_vld  <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        if (empty && !r_emp_vld) begin
                            r_emp_vld  <= 1'b1;
                            r_emp_slot <= r_chk_addr;
                        end
                        if (scan_issue) begin
                            r_chk_vld  <= 1'b1;
                            r_chk_addr <= r_addr[AW-1:0];
                            r_addr     <= r_addr + CW'(1);
                        end else begin
                            r_chk_vld <= 1'b0;
                            if (!r_chk_vld) begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (commit) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupied count above table depth");

    a_read_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_chk_vld |-> ({1'b0, r_chk_addr} < {1'b0, i_lim}))
        else $error("scan read beyond active limit");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after commit");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) || (r_state == S_REL) |-> !ram_we)
        else $error("table written during a scan");
`endif

endmodule

FILE: sv/keyed_handle_registry_with_lock_unit.sv
// Top level of the keyed handle registry with per-entry lock.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------
//   request  | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//   result   | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//   config   | i_cfg_we (no wait)         | i_cfg_wdata (max_entries)
//
// After reset the table memory is swept clear, one slot a cycle; requests are
// held off until the sweep ends.
// Add scans slots 1..limit-1 and remove or acquire scan 0..limit-1 on the single
// read port, one slot a cycle. A key hit ends the scan early. Release reads the
// slot it names without a scan; a zero process id, or a remove or acquire on an
// empty table, skips the scan.
// A finished result waits in the output register; the next request is
// taken while it waits, and a stall only holds the sequencer at its commit.
module keyed_handle_registry_with_lock_unit #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  khr_pkg::t_in_item       i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output khr_pkg::t_out_item      o_out_item,
    input  logic                    i_cfg_we,
    input  logic [khr_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [khr_pkg::CFG_W-1:0] r_max_entries;
    logic                      r_out_vld;
    khr_pkg::t_out_item        r_out_item;

    logic [31:0]               max_ext;
    logic [31:0]               lim_ext;
    logic [CW-1:0]             lim;
    logic                      res_valid;
    logic                      res_ready;
    khr_pkg::t_out_item        res_item;

    // Hold max_entries; a write lands at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= khr_pkg::MAX_ENTRIES_RESET;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    // Saturate the limit to 1..TABLE_DEPTH.
    assign max_ext = 32'(r_max_entries);
    always_comb begin
        if (max_ext == 32'd0) begin
            lim_ext = 32'd1;
        end else if (max_ext > TABLE_DEPTH) begin
            lim_ext = TABLE_DEPTH;
        end else begin
            lim_ext = max_ext;
        end
    end
    assign lim = CW'(lim_ext);

    khr_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_lim       (lim),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_item  (res_item)
    );

    // Output register: take a new result when empty or draining this cycle.
    assign res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

FILE: test/khr_checker.sv
// Scoreboard for the keyed handle registry: predicts each request and checks each response.
module khr_checker #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  khr_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  khr_pkg::t_out_item        i_out_item,
    input  logic                      i_cfg_we,
    input  logic [khr_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);

    logic [63:0]               registry_keys    [TABLE_DEPTH];
    logic [63:0]               registry_handles [TABLE_DEPTH];
    logic                      registry_locks   [TABLE_DEPTH];
    int                        registry_count;
    logic [khr_pkg::CFG_W-1:0] max_entries_cfg;
    khr_pkg::t_out_item        expected_responses[$];
    int                        fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    endtask

    // First slot in [first, lim) holding key, or lim when there is none.
    function automatic int find_slot(input logic [63:0] key, input int first, input int lim);
        int i;
        for (i = first; i < lim; i++)
            if (registry_keys[i] == key) return i;
        return lim;
    endfunction

    function automatic khr_pkg::t_out_item predict_response(input khr_pkg::t_in_item req);
        khr_pkg::t_out_item rsp;
        logic [63:0]        key;
        int                 lim;
        int                 hit;
        int                 free_slot;
        lim = (max_entries_cfg == '0) ? 1 :
              (max_entries_cfg > TABLE_DEPTH) ? int'(TABLE_DEPTH) : int'(max_entries_cfg);
        key = {req.process_id, req.mosaic_index, req.texture_number};
        rsp.status     = khr_pkg::ST_OK;
        rsp.handle_out = '0;
        rsp.slot_out   = '0;
        if (req.req_type == khr_pkg::REQ_RELEASE) begin
            if (int'(req.slot_in) < TABLE_DEPTH) begin
                registry_locks[req.slot_in] = 1'b0;
                rsp.slot_out = req.slot_in;
            end else begin
                rsp.status = khr_pkg::ST_NOT_FOUND;
            end
        end else if (req.process_id == '0) begin
            rsp.status = khr_pkg::ST_ZERO_PID;
        end else if (req.req_type == khr_pkg::REQ_ADD) begin
            hit = find_slot(key, 1, lim);
            if (hit < lim) begin
                rsp.slot_out = 6'(hit);
                if (registry_handles[hit] != req.handle_in) rsp.status = khr_pkg::ST_MISMATCH;
            end else begin
                free_slot = find_slot(64'd0, 1, lim);
                if (free_slot >= lim || registry_count >= lim) begin
                    rsp.status = khr_pkg::ST_FULL;
                end else begin
                    registry_keys[free_slot]    = key;
                    registry_handles[free_slot] = req.handle_in;
                    registry_locks[free_slot]   = 1'b0;
                    registry_count++;
                    rsp.slot_out = 6'(free_slot);
                end
            end
        end else begin
            hit = (registry_count == 0) ? lim : find_slot(key, 0, lim);
            if (hit >= lim) begin
                rsp.status = khr_pkg::ST_NOT_FOUND;
            end else if (registry_locks[hit]) begin
                rsp.status   = khr_pkg::ST_LOCKED;
                rsp.slot_out = 6'(hit);
            end else if (req.req_type == khr_pkg::REQ_REMOVE) begin
                registry_keys[hit]    = '0;
                registry_handles[hit] = '0;
                registry_locks[hit]   = 1'b0;
                if (registry_count > 0) registry_count--;
                rsp.slot_out = 6'(hit);
            end else begin
                registry_locks[hit] = 1'b1;
                rsp.handle_out      = registry_handles[hit];
                rsp.slot_out        = 6'(hit);
            end
        end
        rsp.entry_count = 7'(registry_count);
        return rsp;
    endfunction

    task automatic check_response(input khr_pkg::t_out_item got);
        khr_pkg::t_out_item want;
        if (expected_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding", '0, '0);
            return;
        end
        want = expected_responses.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.handle_out !== want.handle_out)
            report_mismatch("handle_out", got.handle_out, want.handle_out);
        if (got.slot_out !== want.slot_out)
            report_mismatch("slot_out", 64'(got.slot_out), 64'(want.slot_out));
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                registry_keys[i]    = '0;
                registry_handles[i] = '0;
                registry_locks[i]   = 1'b0;
            end
            registry_count  = 0;
            max_entries_cfg = khr_pkg::MAX_ENTRIES_RESET;
            expected_responses.delete();
        end else begin
            if (i_cfg_we) max_entries_cfg = i_cfg_wdata;
            if (i_out_valid && i_out_ready) check_response(i_out_item);
            if (i_in_valid && i_in_ready)
                expected_responses.push_back(predict_response(i_in_item));
        end
        o_pending    <= expected_responses.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the keyed handle registry: stimulus, handshake pacing and verdict.
module tb_top;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int ITEM_TOTAL  = 1900;
    localparam int POOL_SIZE   = 12;
    localparam int PHASE_COUNT = 8;
    localparam int LONG_STALL  = 300;
    localparam int TAIL_CYCLES = 80;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    khr_pkg::t_in_item         i_in_item;
    logic                      o_out_valid;
    logic                      i_out_ready;
    khr_pkg::t_out_item        o_out_item;
    logic                      i_cfg_we;
    logic [khr_pkg::CFG_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending_results;

    // Pacing knobs: the stimulus process sets the percentages, the receiver reads them.
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int stall_asked;
    int stall_served;
    int cur_limit;

    // Keys that recur, so that adds, removes and lock requests find each other.
    logic [31:0] pool_pid     [POOL_SIZE];
    logic [15:0] pool_mosaic  [POOL_SIZE];
    logic [15:0] pool_texture [POOL_SIZE];
    logic [63:0] pool_handle  [POOL_SIZE];

    // Limit settings walked by the random phases; the extremes 0, 1 and 127 are in here.
    int limit_plan [PHASE_COUNT] = '{64, 4, 1, 0, 127, 8, 2, 64};

    keyed_handle_registry_with_lock_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    khr_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: the slowest correct run is well under a fifth of this.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: drop ready at random; on request hold it low for a long stretch,
    // counted here, so the registry backs up and stalls its input.
    initial begin
        i_out_ready  <= 1'b0;
        stall_served = 0;
        forever begin
            @(posedge i_clk);
            if (stall_served != stall_asked) begin
                stall_served++;
                i_out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic khr_pkg::t_in_item request_of(input khr_pkg::t_req req,
                                                     input logic [31:0] pid,
                                                     input logic [15:0] mosaic,
                                                     input logic [15:0] texture,
                                                     input logic [63:0] handle,
                                                     input logic [5:0] slot);
        khr_pkg::t_in_item it;
        it.req_type       = req;
        it.process_id     = pid;
        it.mosaic_index   = mosaic;
        it.texture_number = texture;
        it.handle_in      = handle;
        it.slot_in        = slot;
        return it;
    endfunction

    // Mostly pooled keys with their own handle; some fresh keys, zero process ids
    // and wrong handles as noise. Release slots lean toward the low, occupied end.
    function automatic khr_pkg::t_in_item random_request();
        khr_pkg::t_in_item it;
        int                k;
        int                roll;
        int                slot_hi;
        k = $urandom_range(0, POOL_SIZE - 1);
        it.process_id     = pool_pid[k];
        it.mosaic_index   = pool_mosaic[k];
        it.texture_number = pool_texture[k];
        it.handle_in      = pool_handle[k];
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            it.process_id     = $urandom;
            it.mosaic_index   = 16'($urandom);
            it.texture_number = 16'($urandom);
        end else if (roll < 13) begin
            it.process_id = '0;
        end
        if ($urandom_range(0, 99) < 15) it.handle_in = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 35)      it.req_type = khr_pkg::REQ_ADD;
        else if (roll < 55) it.req_type = khr_pkg::REQ_REMOVE;
        else if (roll < 80) it.req_type = khr_pkg::REQ_ACQUIRE;
        else                it.req_type = khr_pkg::REQ_RELEASE;
        slot_hi = (cur_limit - 1 < 15) ? cur_limit - 1 : 15;
        if ($urandom_range(0, 99) < 70) it.slot_in = 6'($urandom_range(0, slot_hi));
        else                            it.slot_in = 6'($urandom_range(0, 63));
        return it;
    endfunction

    // Offer one item and hold it until the registry takes it.
    task automatic send_request(input khr_pkg::t_in_item item);
        if (items_sent < ITEM_TOTAL / 3) begin
            send_idle_pct = 22;
            recv_idle_pct = 47;
        end else if (items_sent < 2 * ITEM_TOTAL / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 22;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait until every outstanding response has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input int value);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= khr_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_limit = (value < 1) ? 1 : (value > int'(TABLE_DEPTH)) ? int'(TABLE_DEPTH) : value;
    endtask

    initial begin
        khr_pkg::t_in_item key_a;
        logic [31:0]       pid_a;
        logic [15:0]       mos_a;
        logic [15:0]       tex_a;
        logic [63:0]       hnd_a;
        int                per_phase;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        items_sent    = 0;
        stall_asked   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 47;
        cur_limit     = int'(khr_pkg::MAX_ENTRIES_RESET);

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pid[i]     = $urandom;
            if (pool_pid[i] == '0) pool_pid[i] = 32'd1;
            pool_mosaic[i]  = 16'($urandom);
            pool_texture[i] = 16'($urandom);
            pool_handle[i]  = {$urandom, $urandom};
        end
        pid_a = pool_pid[0];
        mos_a = pool_mosaic[0];
        tex_a = pool_texture[0];
        hnd_a = pool_handle[0];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at the reset limit: every request type and the corner answers.
        send_request(request_of(khr_pkg::REQ_ADD, pid_a, mos_a, tex_a, hnd_a, 6'd0));
        send_request(request_of(khr_pkg::REQ_ADD, pid_a, mos_a, tex_a, hnd_a, 6'd0));
        send_request(request_of(khr_pkg::REQ_ADD, pid_a, mos_a, tex_a, ~hnd_a, 6'd0));
        send_request(request_of(khr_pkg::REQ_ADD, 32'd0, mos_a, tex_a, hnd_a, 6'd0));
        send_request(request_of(khr_pkg::REQ_REMOVE, 32'd0, 16'hffff, 16'hffff, '1, 6'd63));
        send_request(request_of(khr_pkg::REQ_ACQUIRE, 32'd0, mos_a, tex_a, hnd_a, 6'd0));
        send_request(request_of(khr_pkg::REQ_ACQUIRE, pid_a, mos_a, tex_a, '0, 6'd0));
        // Locked entry: a second acquire and a remove must both bounce.
        send_request(request_of(khr_pkg::REQ_ACQUIRE, pid_a, mos_a, tex_a, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_REMOVE, pid_a, mos_a, tex_a, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_RELEASE, '1, '1, '1, '1, 6'd1));
        send_request(request_of(khr_pkg::REQ_REMOVE, pid_a, mos_a, tex_a, '0, 6'd0));
        // Empty table: remove finds nothing.
        send_request(request_of(khr_pkg::REQ_REMOVE, pid_a, mos_a, tex_a, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_ADD, '1, '1, '1, '1, 6'd0));
        send_request(request_of(khr_pkg::REQ_ADD, 32'd1, '0, '0, '0, 6'd0));
        // Occupied table, absent key.
        send_request(request_of(khr_pkg::REQ_ACQUIRE, pid_a, mos_a, tex_a, '0, 6'd0));
        // Release of an empty slot and of slot zero still answers ok.
        send_request(request_of(khr_pkg::REQ_RELEASE, '0, '0, '0, '0, 6'd63));
        send_request(request_of(khr_pkg::REQ_RELEASE, '0, '0, '0, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_ACQUIRE, '1, '1, '1, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_REMOVE, 32'd1, '0, '0, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_REMOVE, '1, '1, '1, '0, 6'd0));
        send_request(request_of(khr_pkg::REQ_RELEASE, '1, '1, '1, '0, 6'd1));
        send_request(request_of(khr_pkg::REQ_REMOVE, '1, '1, '1, '0, 6'd0));

        // Random phases, one per limit setting; each starts from a drained block.
        per_phase = ITEM_TOTAL / PHASE_COUNT;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_limit(limit_plan[p]);
            for (int n = 0; n < per_phase; n++) begin
                // Freeze the receiver early in two phases and keep offering items.
                if ((p == 0 || p == 3) && n == 40) stall_asked++;
                key_a = random_request();
                send_request(key_a);
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
